@@ hw/rtl/clnf_pkg.sv @@
// Shared types, codes and constants for the character LCD number formatter.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps

package clnf_pkg;

    // Default sizes handed to the top level parameters.
    localparam int MAX_DIGITS_DEF   = 16;
    localparam int NUMBER_WIDTH_DEF = 16;

    // Request action codes.
    localparam logic [2:0] ACT_INIT = 3'd0;
    localparam logic [2:0] ACT_UDEC = 3'd1;
    localparam logic [2:0] ACT_SDEC = 3'd2;
    localparam logic [2:0] ACT_HEX  = 3'd3;
    localparam logic [2:0] ACT_BIN  = 3'd4;

    // Row code of the top display line.
    localparam logic [1:0] LINE_TOP = 2'd1;

    // LCD command bytes.
    localparam logic [7:0] CMD_FUNC_SET  = 8'h38;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0] ROW2_OFFSET   = 8'h40;

    // Character codes.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // One display request.
    typedef struct packed {
        logic [2:0]  action;
        logic [1:0]  line;
        logic [5:0]  column;
        logic [15:0] number;
        logic [4:0]  length;
    } req_t;

    // One LCD bus write.
    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last_write;
    } wr_t;

    // Digit radix held by the datapath.
    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_HEX,
        BASE_BIN
    } base_t;

    // Source of the byte of the next bus write.
    typedef enum logic [1:0] {
        SEL_INIT,
        SEL_CURSOR,
        SEL_SIGN,
        SEL_DIGIT
    } sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       conv;
        logic       emit;
        logic       dig_dec;
        sel_t       sel;
        logic [1:0] init_idx;
        logic       last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic conv_last;
        logic dig_zero;
        logic dig_one;
        logic out_free;
    } sts_t;

    // Byte of the init sequence at a given position.
    function automatic logic [7:0] init_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = CMD_FUNC_SET;
            2'd1:    b = CMD_DISP_ON;
            2'd2:    b = CMD_ENTRY;
            default: b = CMD_CLEAR;
        endcase
        return b;
    endfunction

    // ASCII character of one digit value, upper-case letters above nine.
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = CH_ZERO + {4'd0, d};
        end
        else
        begin
            c = CH_A + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/clnf_ctrl.sv @@
// Controller state machine of the character LCD number formatter.
// Sequences init commands, conversion, cursor, sign and digit writes.
// Depends on clnf_pkg.
`timescale 1ns / 1ps

module clnf_ctrl
    import clnf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  req_t req_data,
    output logic req_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_INIT,
        S_CURSOR,
        S_SIGN,
        S_DIGITS
    } state_t;

    state_t     state_reg;
    logic [1:0] idx_reg;
    logic       signed_reg;

    // A request is taken only while idle.
    assign req_stall = (state_reg != S_IDLE);

    // Command decode for the current state.
    always_comb
    begin
        cmd          = '0;
        cmd.sel      = SEL_INIT;
        cmd.init_idx = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = req_valid;
            end
            S_CONV:
            begin
                cmd.conv = 1'b1;
            end
            S_INIT:
            begin
                cmd.emit = sts.out_free;
                cmd.sel  = SEL_INIT;
                cmd.last = (idx_reg == 2'd3);
            end
            S_CURSOR:
            begin
                cmd.emit = sts.out_free;
                cmd.sel  = SEL_CURSOR;
                cmd.last = !signed_reg && sts.dig_zero;
            end
            S_SIGN:
            begin
                cmd.emit = sts.out_free;
                cmd.sel  = SEL_SIGN;
                cmd.last = sts.dig_zero;
            end
            S_DIGITS:
            begin
                cmd.emit    = sts.out_free;
                cmd.dig_dec = sts.out_free;
                cmd.sel     = SEL_DIGIT;
                cmd.last    = sts.dig_one;
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

    // State register and sequencing.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= 2'd0;
            signed_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        idx_reg    <= 2'd0;
                        signed_reg <= (req_data.action == ACT_SDEC);
                        priority if (req_data.action == ACT_INIT)
                        begin
                            state_reg <= S_INIT;
                        end
                        else if (req_data.action == ACT_UDEC ||
                                 req_data.action == ACT_SDEC)
                        begin
                            state_reg <= S_CONV;
                        end
                        else if (req_data.action == ACT_HEX ||
                                 req_data.action == ACT_BIN)
                        begin
                            state_reg <= S_CURSOR;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_CONV:
                begin
                    if (sts.conv_last)
                    begin
                        state_reg <= S_CURSOR;
                    end
                end
                S_INIT:
                begin
                    if (sts.out_free)
                    begin
                        idx_reg <= idx_reg + 2'd1;
                        if (idx_reg == 2'd3)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_CURSOR:
                begin
                    if (sts.out_free)
                    begin
                        priority if (signed_reg)
                        begin
                            state_reg <= S_SIGN;
                        end
                        else if (sts.dig_zero)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_DIGITS;
                        end
                    end
                end
                S_SIGN:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= sts.dig_zero ? S_IDLE : S_DIGITS;
                    end
                end
                S_DIGITS:
                begin
                    if (sts.out_free && sts.dig_one)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/clnf_dp.sv @@
// Datapath of the character LCD number formatter: operand registers,
// binary to BCD converter, digit counter, digit select and output register.
// Depends on clnf_pkg.
`timescale 1ns / 1ps

module clnf_dp
    import clnf_pkg::*;
#(
    parameter int MAX_DIGITS   = MAX_DIGITS_DEF,
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req_data,
    input  cmd_t cmd,
    output sts_t sts,
    output logic wr_valid,
    input  logic wr_stall,
    output wr_t  wr_data
);

    localparam int NW      = NUMBER_WIDTH;
    localparam int BCD_N   = (NW * 30103) / 100000 + 1;
    localparam int BCD_W   = 4 * BCD_N;
    localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
    localparam int STEP_W  = $clog2(NW + 1);

    logic [NW-1:0]     val_reg;
    logic [BCD_W-1:0]  bcd_reg;
    logic [CNT_W-1:0]  dig_reg;
    logic [STEP_W-1:0] step_reg;
    logic [7:0]        cursor_reg;
    logic              neg_reg;
    base_t             base_reg;
    logic              wr_valid_reg;
    wr_t               wr_data_reg;

    logic [NW-1:0]     num_w;
    logic [NW-1:0]     num_neg;
    logic              load_neg;
    logic [7:0]        col_m1;
    logic [7:0]        cursor_sum;
    logic [CNT_W-1:0]  len_sat;
    base_t             load_base;
    logic [BCD_W-1:0]  bcd_adj;
    logic [CNT_W-1:0]  pos;
    logic [CNT_W+1:0]  nib_amt;
    logic [NW-1:0]     val_nib_sh;
    logic [NW-1:0]     val_bit_sh;
    logic [BCD_W-1:0]  bcd_sh;
    logic [3:0]        digit;
    logic [7:0]        wr_byte;

    // Operand decode at request load.
    always_comb
    begin
        num_w      = NW'(req_data.number);
        num_neg    = '0 - num_w;
        load_neg   = (req_data.action == ACT_SDEC) && num_w[NW-1];
        col_m1     = {2'b00, req_data.column} - 8'd1;
        cursor_sum = col_m1 + ((req_data.line != LINE_TOP) ? ROW2_OFFSET : 8'h00);
        if (32'(req_data.length) > MAX_DIGITS)
        begin
            len_sat = CNT_W'(MAX_DIGITS);
        end
        else
        begin
            len_sat = CNT_W'(req_data.length);
        end
        priority if (req_data.action == ACT_HEX)
        begin
            load_base = BASE_HEX;
        end
        else if (req_data.action == ACT_BIN)
        begin
            load_base = BASE_BIN;
        end
        else
        begin
            load_base = BASE_DEC;
        end
    end

    // Double-dabble correction: add three to every BCD digit above four.
    always_comb
    begin
        for (int i = 0; i < BCD_N; i++)
        begin
            if (bcd_reg[4*i +: 4] > 4'd4)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // Digit at the current position, zero beyond the converted range.
    always_comb
    begin
        pos        = dig_reg - CNT_W'(1);
        nib_amt    = {pos, 2'b00};
        val_nib_sh = val_reg >> nib_amt;
        val_bit_sh = val_reg >> pos;
        bcd_sh     = bcd_reg >> nib_amt;
        unique case (base_reg)
            BASE_HEX: digit = val_nib_sh[3:0];
            BASE_BIN: digit = {3'b000, val_bit_sh[0]};
            default:  digit = bcd_sh[3:0];
        endcase
    end

    // Byte of the next bus write.
    always_comb
    begin
        unique case (cmd.sel)
            SEL_INIT:   wr_byte = init_byte(cmd.init_idx);
            SEL_CURSOR: wr_byte = cursor_reg;
            SEL_SIGN:   wr_byte = neg_reg ? CH_MINUS : CH_PLUS;
            default:    wr_byte = digit_char(digit);
        endcase
    end

    // Operand, converter and counter registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg    <= load_neg ? num_neg : num_w;
            bcd_reg    <= '0;
            dig_reg    <= len_sat;
            step_reg   <= STEP_W'(NW);
            cursor_reg <= cursor_sum | CMD_SET_DDRAM;
            neg_reg    <= load_neg;
            base_reg   <= load_base;
        end
        else
        begin
            if (cmd.conv)
            begin
                bcd_reg  <= {bcd_adj[BCD_W-2:0], val_reg[NW-1]};
                val_reg  <= {val_reg[NW-2:0], 1'b0};
                step_reg <= step_reg - STEP_W'(1);
            end
            if (cmd.dig_dec)
            begin
                dig_reg <= dig_reg - CNT_W'(1);
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            wr_valid_reg <= 1'b1;
        end
        else if (!wr_stall)
        begin
            wr_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            wr_data_reg.is_data    <= (cmd.sel == SEL_SIGN) || (cmd.sel == SEL_DIGIT);
            wr_data_reg.bus_byte   <= wr_byte;
            wr_data_reg.last_write <= cmd.last;
        end
    end

    assign wr_valid = wr_valid_reg;
    assign wr_data  = wr_data_reg;

    // Status back to the controller.
    always_comb
    begin
        sts.conv_last = (step_reg == STEP_W'(1));
        sts.dig_zero  = (dig_reg == '0);
        sts.dig_one   = (dig_reg == CNT_W'(1));
        sts.out_free  = !wr_valid_reg || !wr_stall;
    end

endmodule

@@ hw/rtl/char_lcd_number_formatter_unit.sv @@
// Character LCD number formatter: turns display requests into LCD bus writes.
// The request channel (req_*) takes one request per transaction; the write
// channel (wr_*) gives one LCD bus write per transaction, last_write marking
// the final write of a request.
// Init requests give four command writes. Number requests give a cursor
// command, a sign in signed decimal, and then the digit field, most
// significant digit first. Action codes above binary are taken and dropped.
// A request is loaded, then converted bit-serially from binary to BCD in decimal
// actions, then gives one write per cycle while the receiver does not stall.
// req_stall is high from the cycle after a request is taken until its last
// write has been placed in the output register; the next request can be
// taken while that last write still waits to be taken.
// A stall on the write channel holds the output register and the sequencer.
// Reset clears the sequencer and empties the output register.
// Depends on clnf_pkg, clnf_ctrl and clnf_dp.
`timescale 1ns / 1ps

module char_lcd_number_formatter_unit
    import clnf_pkg::*;
#(
    parameter int MAX_DIGITS   = MAX_DIGITS_DEF,
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic wr_valid,
    input  logic wr_stall,
    output wr_t  wr_data
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer.
    clnf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_data  (req_data),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Operands, converter and output register.
    clnf_dp #(
        .MAX_DIGITS   (MAX_DIGITS),
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req_data),
        .cmd      (cmd),
        .sts      (sts),
        .wr_valid (wr_valid),
        .wr_stall (wr_stall),
        .wr_data  (wr_data)
    );

endmodule

@@ hw/rtl/clnf_chk.sv @@
// Port-level checker for the character LCD number formatter, bound to the top.
// Depends on clnf_pkg and char_lcd_number_formatter_unit.
`timescale 1ns / 1ps

module clnf_chk
    import clnf_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_stall,
    input req_t req_data,
    input logic wr_valid,
    input logic wr_stall,
    input wr_t  wr_data
);

    // A stalled write stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && wr_stall |=> wr_valid)
        else $error("write dropped while stalled");

    // A stalled write keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && wr_stall |=> $stable(wr_data))
        else $error("write payload changed while stalled");

    // A taken request with a valid action keeps the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall &&
        (req_data.action == ACT_INIT || req_data.action == ACT_UDEC ||
         req_data.action == ACT_SDEC || req_data.action == ACT_HEX ||
         req_data.action == ACT_BIN) |=> req_stall)
        else $error("block idle right after taking a request");

    // A write that is not the last of its request means the block is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_valid && !wr_data.last_write |-> req_stall)
        else $error("idle while a request is unfinished");

    // An idle block with an empty output makes no write on its own.
    assert property (@(posedge clk) disable iff (!rst_n)
        !req_stall && !wr_valid |=> !wr_valid)
        else $error("write appeared without a request");

endmodule

bind char_lcd_number_formatter_unit clnf_chk u_clnf_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .wr_valid  (wr_valid),
    .wr_stall  (wr_stall),
    .wr_data   (wr_data)
);

@@ bench/char_lcd_number_formatter_unit_tb.sv @@
// Self-checking testbench for the character LCD number formatter unit.
// A directed request table and a random phase drive the request channel while
// a local predictor builds the expected LCD bus writes. Depends on clnf_pkg.
`timescale 1ns / 1ps

module char_lcd_number_formatter_unit_tb;

    import clnf_pkg::*;

    localparam int          CLK_PERIOD     = 10;
    localparam int          CYCLE_LIMIT    = 1_000_000;
    localparam int          SETTLE_CYCLES  = 64;
    localparam int          RX_HOLD_CYCLES = 400;
    localparam int          PRESSURE_ITEMS = 12;
    localparam int          QUIET_ITEMS    = 45;
    localparam int          NOISY_ITEMS    = 95;
    localparam logic [2:0]  ACT_LAST_CODE  = 3'd7;
    localparam logic [4:0]  FIELD_DIGITS   = 5'd16;
    localparam logic [15:0] SIGN_BIT       = 16'h8000;

    // One row of stimulus; typed_count < 0 hands the row to the predictor.
    typedef struct {
        req_t       req;
        int         typed_count;
        logic [7:0] typed_bytes [4];
    } request_row_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req_data;
    logic wr_valid;
    logic wr_stall;
    wr_t  wr_data;

    wr_t          pending_writes [$];
    request_row_t directed_rows [$];
    int           fail_count;
    int           cycle_count;
    int           rx_stall_pct;
    int           tx_gap_pct;
    bit           rx_hold_req;

    char_lcd_number_formatter_unit i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .wr_valid  (wr_valid),
        .wr_stall  (wr_stall),
        .wr_data   (wr_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Builds the LCD writes that one request should produce.
    function automatic void format_request(input req_t r);
        wr_t         seq [$];
        logic [7:0]  cursor;
        logic [15:0] magnitude;
        logic [4:0]  n_digits;
        int unsigned radix;
        int unsigned v;
        int unsigned d;
        int          pos;
        int          p;
        if (r.action > ACT_BIN)
        begin
            return;
        end
        if (r.action == ACT_INIT)
        begin
            seq.push_back('{1'b0, CMD_FUNC_SET, 1'b0});
            seq.push_back('{1'b0, CMD_DISP_ON, 1'b0});
            seq.push_back('{1'b0, CMD_ENTRY, 1'b0});
            seq.push_back('{1'b0, CMD_CLEAR, 1'b0});
        end
        else
        begin
            // Cursor address wraps in eight bits, so column zero on the top line
            // gives a command byte of 0xFF.
            cursor = {2'b00, r.column} - 8'd1;
            if (r.line != LINE_TOP)
            begin
                cursor = cursor + ROW2_OFFSET;
            end
            seq.push_back('{1'b0, CMD_SET_DDRAM | cursor, 1'b0});
            magnitude = r.number;
            if (r.action == ACT_SDEC)
            begin
                if ((r.number & SIGN_BIT) != 0)
                begin
                    seq.push_back('{1'b1, CH_MINUS, 1'b0});
                    magnitude = -r.number;
                end
                else
                begin
                    seq.push_back('{1'b1, CH_PLUS, 1'b0});
                end
            end
            case (r.action)
                ACT_HEX: radix = 16;
                ACT_BIN: radix = 2;
                default: radix = 10;
            endcase
            n_digits = (r.length > FIELD_DIGITS) ? FIELD_DIGITS : r.length;
            // Most significant digit first; positions past the value read as zero.
            for (pos = int'(n_digits) - 1; pos >= 0; pos--)
            begin
                v = 32'(magnitude);
                for (p = 0; p < pos && v != 0; p++)
                begin
                    v = v / radix;
                end
                d = v % radix;
                if (d < 10)
                begin
                    seq.push_back('{1'b1, CH_ZERO + 8'(d), 1'b0});
                end
                else
                begin
                    seq.push_back('{1'b1, CH_A + 8'(d - 10), 1'b0});
                end
            end
        end
        seq[seq.size() - 1].last_write = 1'b1;
        foreach (seq[i])
        begin
            pending_writes.push_back(seq[i]);
        end
    endfunction

    // Adds one row to the directed table.
    task automatic add_row(input logic [2:0] act, input logic [1:0] ln,
                           input logic [5:0] col, input logic [15:0] num,
                           input logic [4:0] len, input int typed_count,
                           input logic [7:0] b0, input logic [7:0] b1,
                           input logic [7:0] b2, input logic [7:0] b3);
        request_row_t row;
        row.req            = '{act, ln, col, num, len};
        row.typed_count    = typed_count;
        row.typed_bytes[0] = b0;
        row.typed_bytes[1] = b1;
        row.typed_bytes[2] = b2;
        row.typed_bytes[3] = b3;
        directed_rows.push_back(row);
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int random_gap();
        int pick;
        pick = $urandom_range(99);
        if (pick < 75)
        begin
            return $urandom_range(1, 3);
        end
        if (pick < 95)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic req_t random_request();
        req_t r;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 5)
        begin
            r.action = ACT_INIT;
        end
        else if (pick < 10)
        begin
            r.action = 3'($urandom_range(ACT_BIN + 1, ACT_LAST_CODE));
        end
        else
        begin
            r.action = 3'($urandom_range(ACT_UDEC, ACT_BIN));
        end
        r.line   = ($urandom_range(99) < 80) ? 2'($urandom_range(1, 2)) : 2'($urandom_range(3));
        r.column = ($urandom_range(99) < 80) ? 6'($urandom_range(1, 40)) : 6'($urandom_range(63));
        if ($urandom_range(99) < 20)
        begin
            case ($urandom_range(3))
                0:       r.number = 16'h0000;
                1:       r.number = 16'hFFFF;
                2:       r.number = SIGN_BIT;
                default: r.number = SIGN_BIT - 16'd1;
            endcase
        end
        else
        begin
            r.number = 16'($urandom);
        end
        r.length = ($urandom_range(99) < 85) ? 5'($urandom_range(0, 16))
                                             : 5'($urandom_range(17, 31));
        return r;
    endfunction

    // Offers one request until it is taken, then records what it should produce.
    task automatic offer_row(input request_row_t row);
        wr_t w;
        req_valid <= 1'b1;
        req_data  <= row.req;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        if (row.typed_count < 0)
        begin
            format_request(row.req);
        end
        else
        begin
            for (int i = 0; i < row.typed_count; i++)
            begin
                w.is_data    = (row.req.action != ACT_INIT) && (i != 0);
                w.bus_byte   = row.typed_bytes[i];
                w.last_write = (i == row.typed_count - 1);
                pending_writes.push_back(w);
            end
        end
    endtask

    task automatic offer_random(output bit counted);
        request_row_t row;
        row.req         = random_request();
        row.typed_count = -1;
        counted         = (row.req.action <= ACT_BIN);
        offer_row(row);
    endtask

    task automatic sender_gap();
        int gap;
        if ($urandom_range(99) < tx_gap_pct)
        begin
            gap = random_gap();
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Sender goes quiet until every expected write has come out.
    task automatic drain_writes();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_writes.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Write-channel stall generator; a hold request stalls for a long stretch.
    initial
    begin : write_stall_gen
        int stall_left;
        wr_stall    = 1'b0;
        stall_left  = 0;
        rx_hold_req = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                stall_left  = RX_HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                wr_stall <= 1'b1;
                stall_left--;
            end
            else if (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct)
            begin
                wr_stall <= 1'b1;
                stall_left = random_gap() - 1;
            end
            else
            begin
                wr_stall <= 1'b0;
            end
        end
    end

    // Compares each write transaction with the oldest expected write.
    always @(posedge clk)
    begin : write_check
        wr_t want;
        if (rst_n && wr_valid && !wr_stall)
        begin
            if (pending_writes.size() == 0)
            begin
                $error("unexpected write: is_data %0b, bus_byte %02h, last_write %0b",
                       wr_data.is_data, wr_data.bus_byte, wr_data.last_write);
                fail_count++;
            end
            else
            begin
                want = pending_writes.pop_front();
                if (wr_data.is_data !== want.is_data)
                begin
                    $error("is_data: expected %0b, actual %0b", want.is_data, wr_data.is_data);
                    fail_count++;
                end
                if (wr_data.bus_byte !== want.bus_byte)
                begin
                    $error("bus_byte: expected %02h, actual %02h",
                           want.bus_byte, wr_data.bus_byte);
                    fail_count++;
                end
                if (wr_data.last_write !== want.last_write)
                begin
                    $error("last_write: expected %0b, actual %0b",
                           want.last_write, wr_data.last_write);
                    fail_count++;
                end
            end
        end
    end

    // Run limit.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : main_sequence
        int done_items;
        bit counted;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_data     = '0;
        fail_count   = 0;
        rx_stall_pct = 0;
        tx_gap_pct   = 0;

        // Directed table: action, line, column, number, length, typed count, bytes.
        add_row(ACT_INIT, 2'd1, 6'd1, 16'h0000, 5'd0, 4,
                CMD_FUNC_SET, CMD_DISP_ON, CMD_ENTRY, CMD_CLEAR);
        add_row(ACT_UDEC, 2'd1, 6'd1, 16'h0000, 5'd0, 1, 8'h80, 8'h00, 8'h00, 8'h00);
        add_row(ACT_SDEC, 2'd2, 6'd40, 16'h0000, 5'd0, 2, 8'hE7, CH_PLUS, 8'h00, 8'h00);
        add_row(ACT_UDEC, 2'd1, 6'd0, 16'h0000, 5'd1, 2, 8'hFF, CH_ZERO, 8'h00, 8'h00);
        add_row(ACT_HEX, 2'd2, 6'd0, 16'hFFFF, 5'd1, 2, 8'hBF, 8'h46, 8'h00, 8'h00);
        add_row(ACT_BIN, 2'd0, 6'd1, 16'h0001, 5'd1, 2, 8'hC0, 8'h31, 8'h00, 8'h00);
        add_row(ACT_SDEC, 2'd3, 6'd2, 16'hFFFF, 5'd1, 3, 8'hC1, CH_MINUS, 8'h31, 8'h00);
        add_row(ACT_BIN + 3'd1, 2'd1, 6'd5, 16'h1234, 5'd4, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(ACT_BIN + 3'd2, 2'd2, 6'd9, 16'hFFFF, 5'd16, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(ACT_LAST_CODE, 2'd3, 6'd63, 16'hFFFF, 5'd31, 0, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(ACT_BIN, 2'd3, 6'd63, 16'hFFFF, 5'd16, -1, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(ACT_BIN, 2'd1, 6'd32, 16'hAAAA, 5'd16, -1, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(ACT_BIN, 2'd2, 6'd31, 16'h5555, 5'd20, -1, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(ACT_SDEC, 2'd1, 6'd3, SIGN_BIT, 5'd5, -1, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(ACT_SDEC, 2'd2, 6'd7, SIGN_BIT - 16'd1, 5'd16, -1,
                8'h00, 8'h00, 8'h00, 8'h00);
        add_row(ACT_SDEC, 2'd1, 6'd12, 16'hFFFF, 5'd3, -1, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(ACT_UDEC, 2'd2, 6'd16, 16'hFFFF, 5'd16, -1, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(ACT_UDEC, 2'd1, 6'd20, 16'hFFFF, 5'd31, -1, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(ACT_UDEC, 2'd1, 6'd8, 16'd12345, 5'd3, -1, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(ACT_HEX, 2'd2, 6'd4, 16'hABCD, 5'd4, -1, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(ACT_HEX, 2'd1, 6'd33, 16'h1234, 5'd8, -1, 8'h00, 8'h00, 8'h00, 8'h00);
        add_row(ACT_HEX, 2'd1, 6'd1, 16'h0000, 5'd17, -1, 8'h00, 8'h00, 8'h00, 8'h00);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows with idling on both sides.
        rx_stall_pct = 30;
        tx_gap_pct   = 40;
        foreach (directed_rows[i])
        begin
            offer_row(directed_rows[i]);
            sender_gap();
        end
        drain_writes();

        // Long write-side hold while requests keep coming, so the input backs up.
        rx_stall_pct = 0;
        tx_gap_pct   = 0;
        rx_hold_req  = 1'b1;
        repeat (PRESSURE_ITEMS)
        begin
            offer_random(counted);
        end
        drain_writes();

        // Back-to-back random requests with no idling.
        done_items = 0;
        while (done_items < QUIET_ITEMS)
        begin
            offer_random(counted);
            done_items += counted;
        end

        // Random requests with idling on both sides.
        rx_stall_pct = 35;
        tx_gap_pct   = 35;
        done_items   = 0;
        while (done_items < NOISY_ITEMS)
        begin
            offer_random(counted);
            done_items += counted;
            sender_gap();
        end
        drain_writes();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
